@@ rtl/ett_pkg.sv @@
// Package for the expiring token table: sizes, codes, payload structs.
// Used by ett_ctrl, expiring_token_table_core and the testbench.
package ett_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int KEY_BITS    = 64;

  localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 5;
  localparam int LIFE_W  = 20;
  localparam int TIME_W  = 31;
  localparam int EXP_W   = 32;
  localparam int OWNER_W = 32;

  localparam logic [LIFE_W-1:0] DEFAULT_LIFE_RST = LIFE_W'(3600);

  typedef enum logic [1:0] {
    KIND_CREATE = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_REVOKE = 2'd2,
    KIND_PURGE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ALLOC,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [TIME_W-1:0]  now;
    logic [63:0]        token_key;
    logic [OWNER_W-1:0] owner_id;
    logic [LIFE_W-1:0]  lifetime;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SLOT_W-1:0]  slot;
    logic [OWNER_W-1:0] found_owner;
    logic [EXP_W-1:0]   expiry_time;
    logic [COUNT_W-1:0] active_count;
  } out_item_t;

  // one table entry as held in the entry memory
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [OWNER_W-1:0]  owner;
    logic [EXP_W-1:0]    expiry;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;
  } ram_req_t;

endpackage

@@ rtl/ett_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module ett_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic                             rd_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/ett_ctrl.sv @@
// Sequencer for the token table: scans the entry memory, keeps valid bits
// and the valid count, allocates on create. Depends on ett_pkg.
module ett_ctrl
  import ett_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  input  logic [LIFE_W-1:0] default_lifetime,
  output ram_req_t          ram_req,
  input  entry_t            ram_rd_data,
  output logic              res_valid,
  input  logic              res_ready,
  output out_item_t         res
);

  state_t state, state_next;

  logic [TABLE_DEPTH-1:0] valid_bits;
  logic [CNT_W-1:0]       cnt;

  logic [1:0]          op_kind;
  logic [TIME_W-1:0]   op_now;
  logic [KEY_BITS-1:0] op_key;
  logic [OWNER_W-1:0]  op_owner;
  logic [LIFE_W-1:0]   op_life;

  logic             issue_on;
  logic [IDX_W-1:0] rd_idx;
  logic             ev_on;
  logic [IDX_W-1:0] ev_idx;
  logic             hit_found;

  logic [1:0]         res_status;
  logic [IDX_W-1:0]   res_slot;
  logic [OWNER_W-1:0] res_owner;
  logic [EXP_W-1:0]   res_expiry;

  logic             accept;
  logic             ev_valid;
  logic             ev_expired;
  logic             ev_match;
  logic             free_any;
  logic [IDX_W-1:0] free_idx;
  logic [EXP_W-1:0] new_expiry;

  assign accept     = in_valid && !in_stall;
  assign ev_valid   = ev_on && valid_bits[ev_idx];
  assign ev_expired = {1'b0, op_now} > ram_rd_data.expiry;
  assign ev_match   = ev_valid && (ram_rd_data.key == op_key) && !hit_found;
  assign new_expiry = EXP_W'({1'b0, op_now}) + EXP_W'(op_life);

  // lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_bits[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!issue_on && !ev_on) begin
          state_next = (op_kind == KIND_CREATE) ? ST_ALLOC : ST_FINISH;
        end
      end
      ST_ALLOC:  state_next = ST_FINISH;
      ST_FINISH: begin
        if (res_ready) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall        = (state != ST_IDLE);
    res_valid       = (state == ST_FINISH) && res_ready;
    ram_req.rd_en   = (state == ST_SCAN) && issue_on;
    ram_req.rd_addr = rd_idx;
    ram_req.wr_en   = (state == ST_ALLOC) && free_any;
    ram_req.wr_addr = free_idx;
    ram_req.wr_data = '{key: op_key, owner: op_owner, expiry: new_expiry};
  end

  assign res = '{status:       res_status,
                 slot:         SLOT_W'(res_slot),
                 found_owner:  res_owner,
                 expiry_time:  res_expiry,
                 active_count: COUNT_W'(cnt)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      valid_bits <= '0;
      cnt        <= '0;
      issue_on   <= 1'b0;
      ev_on      <= 1'b0;
      hit_found  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        issue_on  <= 1'b1;
        ev_on     <= 1'b0;
        hit_found <= 1'b0;
      end else if (state == ST_SCAN) begin
        ev_on <= issue_on;
        if (issue_on && rd_idx == IDX_W'(TABLE_DEPTH - 1)) begin
          issue_on <= 1'b0;
        end
        if (op_kind == KIND_LOOKUP || op_kind == KIND_REVOKE) begin
          if (ev_match) begin
            hit_found <= 1'b1;
            if (op_kind == KIND_REVOKE || ev_expired) begin
              valid_bits[ev_idx] <= 1'b0;
              if (cnt != '0) cnt <= cnt - 1'b1;
            end
          end
        end else if (ev_valid && ev_expired) begin
          valid_bits[ev_idx] <= 1'b0;
          if (cnt != '0) cnt <= cnt - 1'b1;
        end
      end else if (state == ST_ALLOC && free_any) begin
        valid_bits[free_idx] <= 1'b1;
        if (cnt < CNT_W'(TABLE_DEPTH)) cnt <= cnt + 1'b1;
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind    <= in_item.kind;
      op_now     <= in_item.now;
      op_key     <= in_item.token_key[KEY_BITS-1:0];
      op_owner   <= in_item.owner_id;
      op_life    <= (in_item.lifetime == '0) ? default_lifetime : in_item.lifetime;
      rd_idx     <= '0;
      res_status <= (in_item.kind == KIND_PURGE) ? STAT_OK : STAT_MISS;
      res_slot   <= '0;
      res_owner  <= '0;
      res_expiry <= '0;
    end else if (state == ST_SCAN) begin
      ev_idx <= rd_idx;
      if (issue_on) rd_idx <= rd_idx + 1'b1;
      if (ev_match && (op_kind == KIND_REVOKE ||
                       (op_kind == KIND_LOOKUP && !ev_expired))) begin
        res_status <= STAT_OK;
        res_slot   <= ev_idx;
        res_owner  <= ram_rd_data.owner;
        res_expiry <= ram_rd_data.expiry;
      end
    end else if (state == ST_ALLOC) begin
      if (free_any) begin
        res_status <= STAT_OK;
        res_slot   <= free_idx;
        res_owner  <= op_owner;
        res_expiry <= new_expiry;
      end else begin
        res_status <= STAT_FULL;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_tracks_valid: assert property (@(posedge clk) disable iff (rst)
    CNT_W'($countones(valid_bits)) == cnt)
    else $error("valid count out of step with valid bits");

  a_write_only_alloc: assert property (@(posedge clk) disable iff (rst)
    ram_req.wr_en |-> (state == ST_ALLOC) && !ram_req.rd_en)
    else $error("entry memory written outside allocation");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SCAN) && issue_on && (rd_idx == '0))
    else $error("accepted transaction did not start a scan");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && !issue_on && !ev_on) |=> state != ST_SCAN)
    else $error("scan did not finish after last read");
`endif

endmodule

@@ rtl/expiring_token_table_core.sv @@
// Top level of the expiring token table: config register, output register,
// sequencer and entry memory. Depends on ett_pkg, ett_ctrl, ett_ram.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------
//  input    | in_valid / in_stall     | in_item  (in_item_t)
//  output   | out_valid / out_stall   | out_item (out_item_t)
//  config   | cfg_valid / cfg_ready   | cfg_data (default lifetime)
//
// One read a cycle over the entry memory during the scan; each registered read is checked,
// then the sequencer goes to finish (create through an allocation state first) and the
// result enters the output register when it is free; the next accept follows in idle.
// Input accepted only while the sequencer is idle; a finished result may
// wait in the output register while the next transaction runs.
// Synchronous reset clears valid bits and count; memory contents are not cleared.
module expiring_token_table_core
  import ett_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LIFE_W-1:0] cfg_data
);

  logic [LIFE_W-1:0] default_lifetime;
  ram_req_t          ram_req;
  entry_t            ram_rd_data;
  logic [ENTRY_W-1:0] ram_rd_bits;
  logic              res_valid;
  logic              res_ready;
  out_item_t         res;

  assign cfg_ready   = 1'b1;
  assign res_ready   = !out_valid || !out_stall;
  assign ram_rd_data = entry_t'(ram_rd_bits);

  always_ff @(posedge clk) begin
    if (rst) begin
      default_lifetime <= DEFAULT_LIFE_RST;
    end else if (cfg_valid && cfg_ready) begin
      default_lifetime <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) out_item <= res;
  end

  ett_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_item          (in_item),
    .default_lifetime (default_lifetime),
    .ram_req          (ram_req),
    .ram_rd_data      (ram_rd_data),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res              (res)
  );

  ett_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (ram_rd_bits)
  );

endmodule

@@ tb/sv/ett_checker.sv @@
// Checker for expiring_token_table_core: watches the item, reply and config channels,
// keeps a shadow token table and compares each reply with the predicted one.
// Depends on ett_pkg.
module ett_checker
  import ett_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_item_t          in_item,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_item_t         out_item,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [LIFE_W-1:0] cfg_data,
  output int                errors,
  output int                replies_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the token table
  logic                tbl_valid  [TABLE_DEPTH];
  logic [KEY_BITS-1:0] tbl_key    [TABLE_DEPTH];
  logic [OWNER_W-1:0]  tbl_owner  [TABLE_DEPTH];
  logic [EXP_W-1:0]    tbl_expiry [TABLE_DEPTH];
  int                  live_count;
  logic [LIFE_W-1:0]   life_default;

  out_item_t owed_replies [$];
  int        err_cnt;
  int        reply_no;

  function automatic void report(string msg);
    if (err_cnt < 10)
      $display("%0t: reply %0d: %s", $realtime, reply_no, msg);
    err_cnt++;
  endfunction

  function automatic void cmp_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want)
      report($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
  endfunction

  function automatic void drop_slot(int i);
    tbl_valid[i] = 1'b0;
    if (live_count > 0)
      live_count--;
  endfunction

  function automatic void purge_stale(logic [EXP_W-1:0] now32);
    int i;
    for (i = 0; i < TABLE_DEPTH; i++)
      if (tbl_valid[i] && now32 > tbl_expiry[i])
        drop_slot(i);
  endfunction

  // lowest valid entry holding the key, -1 if none
  function automatic int find_live(logic [KEY_BITS-1:0] key);
    int i;
    for (i = 0; i < TABLE_DEPTH; i++)
      if (tbl_valid[i] && tbl_key[i] == key)
        return i;
    return -1;
  endfunction

  function automatic out_item_t apply_token_op(in_item_t it);
    out_item_t           r;
    logic [EXP_W-1:0]    now32;
    logic [LIFE_W-1:0]   life;
    logic [KEY_BITS-1:0] key;
    int                  hit;
    int                  i;
    r = '0;
    r.status = STAT_MISS;
    now32 = {1'b0, it.now};
    key = it.token_key[KEY_BITS-1:0];
    case (kind_t'(it.kind))
      KIND_CREATE: begin
        life = (it.lifetime == '0) ? life_default : it.lifetime;
        purge_stale(now32);
        hit = -1;
        for (i = TABLE_DEPTH - 1; i >= 0; i--)
          if (!tbl_valid[i])
            hit = i;
        if (hit < 0) begin
          r.status = STAT_FULL;
        end else begin
          tbl_valid[hit]  = 1'b1;
          tbl_key[hit]    = key;
          tbl_owner[hit]  = it.owner_id;
          tbl_expiry[hit] = now32 + EXP_W'(life);
          if (live_count < TABLE_DEPTH)
            live_count++;
          r.status      = STAT_OK;
          r.slot        = SLOT_W'(hit);
          r.found_owner = it.owner_id;
          r.expiry_time = tbl_expiry[hit];
        end
      end
      KIND_LOOKUP: begin
        hit = find_live(key);
        if (hit >= 0) begin
          if (now32 > tbl_expiry[hit]) begin
            drop_slot(hit);
          end else begin
            r.status      = STAT_OK;
            r.slot        = SLOT_W'(hit);
            r.found_owner = tbl_owner[hit];
            r.expiry_time = tbl_expiry[hit];
          end
        end
      end
      KIND_REVOKE: begin
        hit = find_live(key);
        if (hit >= 0) begin
          drop_slot(hit);
          r.status      = STAT_OK;
          r.slot        = SLOT_W'(hit);
          r.found_owner = tbl_owner[hit];
          r.expiry_time = tbl_expiry[hit];
        end
      end
      default: begin
        purge_stale(now32);
        r.status = STAT_OK;
      end
    endcase
    r.active_count = COUNT_W'(live_count);
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++)
        tbl_valid[i] = 1'b0;
      live_count   = 0;
      life_default = DEFAULT_LIFE_RST;
      owed_replies.delete();
    end else begin
      // replies first: a reply never belongs to a transaction accepted at the same edge
      if (out_valid && !out_stall) begin
        if (owed_replies.size() == 0) begin
          report($sformatf("reply with nothing outstanding: %p", out_item));
        end else begin
          want = owed_replies.pop_front();
          cmp_field("status", 64'(want.status), 64'(out_item.status));
          cmp_field("slot", 64'(want.slot), 64'(out_item.slot));
          cmp_field("found_owner", 64'(want.found_owner), 64'(out_item.found_owner));
          cmp_field("expiry_time", 64'(want.expiry_time), 64'(out_item.expiry_time));
          cmp_field("active_count", 64'(want.active_count), 64'(out_item.active_count));
        end
        reply_no++;
      end
      if (cfg_valid && cfg_ready)
        life_default = cfg_data;
      if (in_valid && !in_stall)
        owed_replies.push_back(apply_token_op(in_item));
    end
    errors       <= err_cnt;
    replies_owed <= owed_replies.size();
  end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top for expiring_token_table_core: clock, reset, stimulus and verdict.
// Depends on ett_pkg, expiring_token_table_core and ett_checker.
module tb
  import ett_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_N = 6;

  logic              clk;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_item_t          in_item   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_item;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [LIFE_W-1:0] cfg_data  = '0;

  int errors;
  int replies_owed;
  int idle_pct  = 0;
  int stall_pct = 0;

  logic [63:0]       key_pool [POOL_N];
  logic [TIME_W-1:0] clock_s;

  expiring_token_table_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  ett_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_item     (out_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .replies_owed (replies_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic in_item_t make_op(kind_t k, logic [TIME_W-1:0] now, logic [63:0] key,
                                       logic [OWNER_W-1:0] owner, logic [LIFE_W-1:0] life);
    in_item_t it;
    it.kind      = k;
    it.now       = now;
    it.token_key = key;
    it.owner_id  = owner;
    it.lifetime  = life;
    return it;
  endfunction

  // valid stays high across back-to-back transactions
  task automatic send_op(input in_item_t it);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct)
      gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
  endtask

  task automatic write_default_life(input logic [LIFE_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly a slowly advancing clock with keys from a small pool, so entries
  // collide, get looked up, revoked and expire; rare time jumps and stray keys
  task automatic run_random(input int n_ops);
    int                n;
    int                pick;
    kind_t             k;
    logic [63:0]       key;
    logic [LIFE_W-1:0] life;
    for (n = 0; n < n_ops; n++) begin
      if ($urandom_range(99) == 0)
        clock_s = TIME_W'($urandom());
      else
        clock_s = clock_s + TIME_W'($urandom_range(12));
      if ($urandom_range(99) < 2)
        key_pool[$urandom_range(POOL_N - 1)] = {$urandom(), $urandom()};
      if ($urandom_range(99) < 85)
        key = key_pool[$urandom_range(POOL_N - 1)];
      else
        key = {$urandom(), $urandom()};
      pick = $urandom_range(99);
      if (pick < 25)
        life = '0;
      else if (pick < 85)
        life = LIFE_W'($urandom_range(60, 1));
      else if (pick < 95)
        life = LIFE_W'($urandom());
      else
        life = '1;
      pick = $urandom_range(99);
      if (pick < 40)
        k = KIND_CREATE;
      else if (pick < 70)
        k = KIND_LOOKUP;
      else if (pick < 85)
        k = KIND_REVOKE;
      else
        k = KIND_PURGE;
      send_op(make_op(k, clock_s, key, OWNER_W'($urandom()), life));
      if ($urandom_range(99) == 0)
        pause_until_drained();
    end
  endtask

  initial begin
    int                p;
    int                i;
    logic [LIFE_W-1:0] life_cfg;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, extremes, duplicates, expiry edge, full table
    idle_pct  = 30;
    stall_pct = 30;
    send_op(make_op(KIND_LOOKUP, '0, 64'd5, '0, '0));
    send_op(make_op(KIND_REVOKE, '0, 64'd5, '0, '0));
    send_op(make_op(KIND_PURGE, '0, '0, '0, '0));
    send_op(make_op(KIND_CREATE, '1, '1, '1, '1));
    send_op(make_op(KIND_CREATE, '0, '0, '0, '0));
    send_op(make_op(KIND_CREATE, '0, '0, 32'h1234_5678, 20'd10));
    send_op(make_op(KIND_LOOKUP, 31'd5, '0, '0, '0));
    send_op(make_op(KIND_REVOKE, 31'd5, '0, '0, '0));
    send_op(make_op(KIND_LOOKUP, 31'd10, '0, '0, '0));
    send_op(make_op(KIND_LOOKUP, 31'd11, '0, '0, '0));
    send_op(make_op(KIND_CREATE, 31'd20, 64'hA5A5_5A5A_F00F_0FF0, 32'hDEAD_BEEF, 20'd1));
    send_op(make_op(KIND_PURGE, 31'd22, '0, '0, '0));
    for (i = 0; i < TABLE_DEPTH; i++)
      send_op(make_op(KIND_CREATE, 31'd30, {$urandom(), $urandom()}, OWNER_W'($urandom()),
                      20'd1000));
    send_op(make_op(KIND_PURGE, 31'd2000, '0, '0, '0));
    send_op(make_op(KIND_LOOKUP, '1, '1, '0, '0));
    send_op(make_op(KIND_REVOKE, '1, '1, '0, '0));

    for (i = 0; i < POOL_N; i++)
      key_pool[i] = {$urandom(), $urandom()};
    clock_s = '0;

    for (p = 0; p < 4; p++) begin
      pause_until_drained();
      repeat (2 * TABLE_DEPTH) @(posedge clk);
      case (p)
        0: life_cfg = LIFE_W'(1);
        1: life_cfg = '1;
        2: life_cfg = '0;
        default: life_cfg = LIFE_W'($urandom());
      endcase
      write_default_life(life_cfg);
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      run_random(175);
    end

    pause_until_drained();
    repeat (4 * TABLE_DEPTH) @(posedge clk);
    if (errors == 0)
      $display("PASS expiring_token_table_core");
    else
      $display("FAIL expiring_token_table_core");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL expiring_token_table_core");
    $finish;
  end

endmodule
